FILE: hdl/fils_pkg.sv
// Shared types and constants for the face identity label stabilizer.
package fils_pkg;

  localparam int unsigned NEAR_DIST_SQ = 40 * 40;
  localparam int unsigned SCORE_W      = 16;
  localparam int unsigned CNT8_W       = 8;
  localparam logic [7:0]  COUNT_MAX    = 8'd255;
  localparam int unsigned DRAIN_LEN    = 5;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        REG_MIN_HITS    = 1'b0;
  localparam logic        REG_HOLD_FRAMES = 1'b1;
  localparam logic [7:0]  MIN_HITS_RST    = 8'd2;
  localparam logic [7:0]  HOLD_FRAMES_RST = 8'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_UPDATE
  } fils_state_t;

endpackage

FILE: hdl/fils_ram.sv
// Generic simple dual-port RAM with registered read.
module fils_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/fils_pair_score.sv
// Three-stage pipeline that scores a face box against one stored slot box.
module fils_pair_score #(
  parameter int COORD_BITS = 12,
  parameter int TAG_W      = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic [TAG_W-1:0]          in_tag,
  input  logic [COORD_BITS-1:0]     bx,
  input  logic [COORD_BITS-1:0]     by,
  input  logic [COORD_BITS-1:0]     bw,
  input  logic [COORD_BITS-1:0]     bh,
  input  logic [2*COORD_BITS-1:0]   b_area,
  input  logic [COORD_BITS-1:0]     sx,
  input  logic [COORD_BITS-1:0]     sy,
  input  logic [COORD_BITS-1:0]     sw,
  input  logic [COORD_BITS-1:0]     sh,
  output logic                      out_vld,
  output logic [TAG_W-1:0]          out_tag,
  output logic [2*COORD_BITS+1:0]   num,
  output logic [2*COORD_BITS+1:0]   den
);
  import fils_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int NW = 2 * COORD_BITS + 2;

  // stage 1: overlap extents and centre distances
  logic [C:0]   bx2, by2, sx2, sy2, ex2, ey2, ex1, ey1, cbx, cby, csx, csy;
  logic [C:0]   iw_nxt, ih_nxt, dx_nxt, dy_nxt;
  logic [C-1:0] mw_nxt, mh_nxt;
  logic [C:0]   iw_r, ih_r, dx_r, dy_r;
  logic [C-1:0] mw_r, mh_r, sw_r, sh_r;
  logic         v1_r, v2_r, v3_r;
  logic [TAG_W-1:0] t1_r, t2_r, t3_r;

  always_comb begin
    bx2 = {1'b0, bx} + {1'b0, bw};
    by2 = {1'b0, by} + {1'b0, bh};
    sx2 = {1'b0, sx} + {1'b0, sw};
    sy2 = {1'b0, sy} + {1'b0, sh};
    ex2 = (bx2 < sx2) ? bx2 : sx2;
    ey2 = (by2 < sy2) ? by2 : sy2;
    ex1 = (bx > sx) ? {1'b0, bx} : {1'b0, sx};
    ey1 = (by > sy) ? {1'b0, by} : {1'b0, sy};
    iw_nxt = (ex2 > ex1) ? ex2 - ex1 : '0;
    ih_nxt = (ey2 > ey1) ? ey2 - ey1 : '0;
    cbx = {1'b0, bx} + {2'b0, bw[C-1:1]};
    cby = {1'b0, by} + {2'b0, bh[C-1:1]};
    csx = {1'b0, sx} + {2'b0, sw[C-1:1]};
    csy = {1'b0, sy} + {2'b0, sh[C-1:1]};
    dx_nxt = (cbx > csx) ? cbx - csx : csx - cbx;
    dy_nxt = (cby > csy) ? cby - csy : csy - cby;
    mw_nxt = (bw > sw) ? bw : sw;
    mh_nxt = (bh > sh) ? bh : sh;
  end

  // stage 2: products
  logic [NW-1:0] inter_r, s_area_r, dd_r, mm_r;

  // stage 3: union, near test, fraction
  logic [NW-1:0] uni, lim, mm_q;
  logic          near;
  logic [NW-1:0] num_r, den_r;

  always_comb begin
    uni  = NW'(b_area) + s_area_r - inter_r;
    mm_q = mm_r >> 2;
    lim  = (mm_q > NW'(NEAR_DIST_SQ)) ? mm_q : NW'(NEAR_DIST_SQ);
    near = (dd_r <= lim) && ({2'b0, uni} > {inter_r, 2'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    t1_r     <= in_tag;
    iw_r     <= iw_nxt;
    ih_r     <= ih_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    mw_r     <= mw_nxt;
    mh_r     <= mh_nxt;
    sw_r     <= sw;
    sh_r     <= sh;
    t2_r     <= t1_r;
    inter_r  <= NW'(iw_r) * NW'(ih_r);
    s_area_r <= NW'(sw_r) * NW'(sh_r);
    dd_r     <= NW'(dx_r) * NW'(dx_r) + NW'(dy_r) * NW'(dy_r);
    mm_r     <= NW'(mw_r) * NW'(mw_r) + NW'(mh_r) * NW'(mh_r);
    t3_r     <= t2_r;
    num_r    <= near ? NW'(1) : inter_r;
    den_r    <= near ? NW'(4) : uni;
  end

  assign out_vld = v3_r;
  assign out_tag = t3_r;
  assign num     = num_r;
  assign den     = den_r;

endmodule

FILE: hdl/face_identity_label_stabilizer.sv
// Top level: face identity label stabilizer with ping-pong slot memory.
// Each face word is scored against the N previous-frame slots (1..MAX_FACES); the scan
//   is skipped with no previous slots or a full frame. The slot scan issues a memory read
//   in one phase and waits in the other, set by the
//   best-match compare loop (multiply, then compare).
// A new face is taken only while idle, after the last one's result is registered; an empty word keeps the block idle.
// Reset: control state, counts, taken mask and registers clear at once; slot memory
//   needs no clearing since only entries below the fill count are ever read.
module face_identity_label_stabilizer #(
  parameter int MAX_FACES  = 16,
  parameter int COORD_BITS = 12,
  parameter int ID_BITS    = 10
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata: box_left, box_top, box_right, box_bottom, recognized, person_id, raw_score
  input  logic [((4*COORD_BITS+ID_BITS+17+7)/8)*8-1:0] in_tdata,
  input  logic                                         in_tuser,  // face_valid
  input  logic                                         in_tlast,  // frame_end
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // out_tdata: stable_id, reported score
  output logic [((ID_BITS+16+7)/8)*8-1:0]              out_tdata,
  output logic                                         out_tuser, // known
  output logic                                         out_tlast, // last_of_frame
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  input  logic                                         cfg_psel,
  input  logic                                         cfg_penable,
  input  logic                                         cfg_pwrite,
  input  logic [fils_pkg::CFG_ADDR_W-1:0]              cfg_paddr,
  input  logic [fils_pkg::CFG_DATA_W-1:0]              cfg_pwdata,
  output logic [fils_pkg::CFG_DATA_W-1:0]              cfg_prdata,
  output logic                                         cfg_pready
);
  import fils_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int NW     = 2 * C + 2;
  localparam int IDX_W  = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int CNT_W  = $clog2(MAX_FACES + 1);
  localparam int ADDR_W = IDX_W + 1;
  localparam int LBL_W  = 2 * ID_BITS + 2 + SCORE_W + 2 * CNT8_W;
  localparam int SLOT_W = 4 * C + LBL_W;
  localparam int TAG_W  = IDX_W + LBL_W;
  localparam int IN_W   = ((4*C+ID_BITS+17+7)/8)*8;
  localparam int OUT_W  = ((ID_BITS+16+7)/8)*8;
  localparam int FW     = NW + 5;
  // input word layout
  localparam int OFF_T   = C;
  localparam int OFF_R   = 2 * C;
  localparam int OFF_B   = 3 * C;
  localparam int OFF_REC = 4 * C;
  localparam int OFF_PID = 4 * C + 1;
  localparam int OFF_SC  = 4 * C + 1 + ID_BITS;
  // label layout, low bits first: missed, hits, stab_score, stab_id, stab_valid,
  // cand_id, cand_valid
  localparam int L_HITS  = CNT8_W;
  localparam int L_SSC   = 2 * CNT8_W;
  localparam int L_SID   = 2 * CNT8_W + SCORE_W;
  localparam int L_SV    = L_SID + ID_BITS;
  localparam int L_CID   = L_SV + 1;
  localparam int L_CV    = L_CID + ID_BITS;

  // ---------------- configuration registers
  logic [7:0] min_hits_r, hold_frames_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_hits_r    <= MIN_HITS_RST;
      hold_frames_r <= HOLD_FRAMES_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_MIN_HITS:    min_hits_r    <= cfg_pwdata[7:0];
        REG_HOLD_FRAMES: hold_frames_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_MIN_HITS:    cfg_prdata = {{(CFG_DATA_W-8){1'b0}}, min_hits_r};
      REG_HOLD_FRAMES: cfg_prdata = {{(CFG_DATA_W-8){1'b0}}, hold_frames_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // ---------------- control state
  fils_state_t state_r, state_nxt;
  logic                 bank_r;         // bank holding the previous frame's slots
  logic [CNT_W-1:0]     old_cnt_r, new_cnt_r;
  logic [MAX_FACES-1:0] taken_r;
  logic [CNT_W-1:0]     idx_r;
  logic                 phase_r;
  logic [2:0]           drain_r;
  logic                 room_r;

  // latched input word
  logic [C-1:0]       l_r, t_r, r_r, b_r;
  logic               rec_r, fe_r;
  logic [ID_BITS-1:0] pid_r;
  logic [SCORE_W-1:0] score_r;

  // current face box
  logic [C-1:0]   bx_r, by_r, bw_r, bh_r;
  logic [2*C-1:0] ab_r;
  logic [C-1:0]   bx_nxt, by_nxt, bw_nxt, bh_nxt, dwx, dwy;

  logic in_fire, out_free, upd_fire, last_issue;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_tvalid || out_tready;
  assign upd_fire = (state_r == ST_UPDATE) && out_free;
  assign last_issue = (idx_r == old_cnt_r - CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_fire && in_tuser) state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ((new_cnt_r < CNT_W'(MAX_FACES)) && old_cnt_r != '0) ?
                             ST_SCAN : ST_DECIDE;
      ST_SCAN:   if (!phase_r && last_issue) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (drain_r == 3'(DRAIN_LEN - 1)) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_UPDATE;
      ST_UPDATE: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  logic rd_issue;
  always_comb begin
    in_tready = 1'b0;
    rd_issue  = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_SCAN: rd_issue  = !phase_r;
      default: ;
    endcase
  end

  // box normalization: sort edges, floor width and height at one
  always_comb begin
    bx_nxt = (l_r < r_r) ? l_r : r_r;
    by_nxt = (t_r < b_r) ? t_r : b_r;
    dwx    = (l_r < r_r) ? r_r - l_r : l_r - r_r;
    dwy    = (t_r < b_r) ? b_r - t_r : t_r - b_r;
    bw_nxt = (dwx == '0) ? C'(1) : dwx;
    bh_nxt = (dwy == '0) ? C'(1) : dwy;
  end

  // ---------------- slot memory (two banks: previous and current frame)
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [SLOT_W-1:0] ram_wdata, ram_rdata;

  assign ram_raddr = {bank_r, idx_r[IDX_W-1:0]};
  assign ram_waddr = {!bank_r, new_cnt_r[IDX_W-1:0]};
  assign ram_we    = upd_fire && room_r;

  fils_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (2 ** ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (rd_issue),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // read data returns in the cycle after issue; drop slots already claimed this frame
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_issue && !taken_r[idx_r[IDX_W-1:0]];
    end
    rd_idx_r <= idx_r[IDX_W-1:0];
  end

  // ---------------- pair scoring pipeline
  logic              sc_vld;
  logic [TAG_W-1:0]  sc_tag;
  logic [NW-1:0]     sc_num, sc_den;

  fils_pair_score #(
    .COORD_BITS (C),
    .TAG_W      (TAG_W)
  ) u_score (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rd_vld_r),
    .in_tag  ({rd_idx_r, ram_rdata[LBL_W-1:0]}),
    .bx      (bx_r),
    .by      (by_r),
    .bw      (bw_r),
    .bh      (bh_r),
    .b_area  (ab_r),
    .sx      (ram_rdata[SLOT_W-1 -: C]),
    .sy      (ram_rdata[SLOT_W-1-C -: C]),
    .sw      (ram_rdata[SLOT_W-1-2*C -: C]),
    .sh      (ram_rdata[SLOT_W-1-3*C -: C]),
    .out_vld (sc_vld),
    .out_tag (sc_tag),
    .num     (sc_num),
    .den     (sc_den)
  );

  // best-match loop: cross-multiply against the running best, then compare
  logic [NW-1:0]    bn_r, bd_r, m_num_r, m_den_r;
  logic [2*NW-1:0]  p_new_r, p_best_r;
  logic             m_vld_r, found_r, match_r;
  logic [TAG_W-1:0] m_tag_r, best_tag_r;
  logic [FW-1:0]    bd3, bn20;

  assign bd3  = (FW'(bd_r) << 1) + FW'(bd_r);
  assign bn20 = (FW'(bn_r) << 4) + (FW'(bn_r) << 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= sc_vld;
    end
    p_new_r  <= (2*NW)'(sc_num) * (2*NW)'(bd_r);
    p_best_r <= (2*NW)'(bn_r) * (2*NW)'(sc_den);
    m_num_r  <= sc_num;
    m_den_r  <= sc_den;
    m_tag_r  <= sc_tag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (state_r == ST_PREP) begin
        found_r <= 1'b0;
      end else if (m_vld_r && p_new_r > p_best_r) begin
        found_r <= 1'b1;
      end
      // accept when best >= 3/20
      if (state_r == ST_DECIDE) begin
        match_r <= found_r && (bd3 <= bn20);
      end
    end
    if (state_r == ST_PREP) begin
      bn_r <= '0;
      bd_r <= NW'(1);
    end else if (m_vld_r && p_new_r > p_best_r) begin
      bn_r       <= m_num_r;
      bd_r       <= m_den_r;
      best_tag_r <= m_tag_r;
    end
  end

  // ---------------- label update
  logic [LBL_W-1:0]   base, lbl_nxt;
  logic               cv, sv;
  logic [ID_BITS-1:0] cid, sid;
  logic [SCORE_W-1:0] ssc;
  logic [7:0]         hits, missed;
  logic               known;
  logic [ID_BITS-1:0] id_o;
  logic [SCORE_W-1:0] osc, hmax;
  logic [IDX_W-1:0]   best_idx;

  assign best_idx = best_tag_r[TAG_W-1 -: IDX_W];

  always_comb begin
    base   = match_r ? best_tag_r[LBL_W-1:0] : '0;
    cv     = base[L_CV];
    cid    = base[L_CID +: ID_BITS];
    sv     = base[L_SV];
    sid    = base[L_SID +: ID_BITS];
    ssc    = base[L_SSC +: SCORE_W];
    hits   = base[L_HITS +: CNT8_W];
    missed = base[0 +: CNT8_W];
    known  = rec_r;
    id_o   = pid_r;
    osc    = score_r;
    hmax   = ($signed(score_r) > $signed(ssc)) ? score_r : ssc;
    if (!rec_r) begin
      if (missed != COUNT_MAX) missed = missed + 8'd1;
      if (sv && missed <= hold_frames_r) begin
        known = 1'b1;
        id_o  = sid;
        osc   = hmax;
      end else begin
        cv   = 1'b0;
        cid  = '0;
        hits = '0;
      end
    end else begin
      if (cv && cid == pid_r) begin
        if (hits != COUNT_MAX) hits = hits + 8'd1;
      end else begin
        cv   = 1'b1;
        cid  = pid_r;
        hits = 8'd1;
      end
      missed = '0;
      if (hits >= min_hits_r) begin
        sv  = 1'b1;
        sid = pid_r;
        ssc = score_r;
      end else if (sv && sid == pid_r) begin
        osc = hmax;
      end else begin
        known = 1'b0;
      end
    end
    lbl_nxt = {cv, cid, sv, sid, ssc, hits, missed};
  end

  assign ram_wdata = {bx_r, by_r, bw_r, bh_r, lbl_nxt};

  // ---------------- sequencing registers
  logic [CNT_W-1:0] cnt_after;
  assign cnt_after = room_r ? new_cnt_r + CNT_W'(1) : new_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bank_r    <= 1'b0;
      old_cnt_r <= '0;
      new_cnt_r <= '0;
      taken_r   <= '0;
      idx_r     <= '0;
      phase_r   <= 1'b0;
      drain_r   <= '0;
      room_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          // empty word closing a frame: swap banks now
          if (in_fire && !in_tuser && in_tlast) begin
            bank_r    <= !bank_r;
            old_cnt_r <= new_cnt_r;
            new_cnt_r <= '0;
            taken_r   <= '0;
          end
        end
        ST_PREP: begin
          room_r  <= (new_cnt_r < CNT_W'(MAX_FACES));
          idx_r   <= '0;
          phase_r <= 1'b0;
          drain_r <= '0;
        end
        ST_SCAN: begin
          phase_r <= !phase_r;
          if (phase_r) idx_r <= idx_r + CNT_W'(1);
        end
        ST_DRAIN: drain_r <= drain_r + 3'd1;
        ST_UPDATE: begin
          if (out_free) begin
            if (fe_r) begin
              bank_r    <= !bank_r;
              old_cnt_r <= cnt_after;
              new_cnt_r <= '0;
              taken_r   <= '0;
            end else begin
              new_cnt_r <= cnt_after;
              if (match_r) taken_r[best_idx] <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload: latch the word, then the normalized box
  always_ff @(posedge clk) begin
    if (in_fire) begin
      l_r     <= in_tdata[0 +: C];
      t_r     <= in_tdata[OFF_T +: C];
      r_r     <= in_tdata[OFF_R +: C];
      b_r     <= in_tdata[OFF_B +: C];
      rec_r   <= in_tdata[OFF_REC];
      pid_r   <= in_tdata[OFF_PID +: ID_BITS];
      score_r <= in_tdata[OFF_SC +: SCORE_W];
      fe_r    <= in_tlast;
    end
    if (state_r == ST_PREP) begin
      bx_r <= bx_nxt;
      by_r <= by_nxt;
      bw_r <= bw_nxt;
      bh_r <= bh_nxt;
      ab_r <= (2*C)'(bw_nxt) * (2*C)'(bh_nxt);
    end
  end

  // ---------------- output register
  logic out_vld_r;
  logic [OUT_W-1:0] out_data_r;
  logic out_known_r, out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (upd_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (upd_fire) begin
      out_data_r  <= OUT_W'({osc, known ? id_o : {ID_BITS{1'b0}}});
      out_known_r <= known;
      out_last_r  <= fe_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_known_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the face identity label stabilizer.
`timescale 1ns / 1ps

module testbench;
  import fils_pkg::*;

  localparam int FACES      = 16;
  localparam int CYCLE_CAP  = 1000000;
  // settle time after the last label; longer than the worst face latency
  localparam int SETTLE     = 60;
  localparam logic [CFG_ADDR_W-1:0] ADDR_MIN_HITS    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_HOLD_FRAMES = 3'd4;

  typedef struct {
    bit                 valid;
    bit [11:0]          left, top, right, bottom;
    bit                 recognized;
    bit [9:0]           person;
    logic signed [15:0] score;
    bit                 last;
  } face_t;

  typedef struct {
    bit        known;
    bit [9:0]  id;
    bit [15:0] score;
    bit        last;
  } label_t;

  // one tracked face as the stabilizer remembers it
  typedef struct {
    longint unsigned    x, y, w, h;
    bit                 cand_v;
    bit [9:0]           cand_id;
    bit                 stab_v;
    bit [9:0]           stab_id;
    logic signed [15:0] stab_score;
    int unsigned        hits, missed;
  } track_t;

  logic        clk;
  logic        rst_n;
  logic [79:0] in_tdata;   // left, top, right, bottom, recognized, person_id, raw_score
  logic        in_tuser;   // face_valid
  logic        in_tlast;   // frame_end
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] out_tdata;  // stable_id, reported score
  logic        out_tuser;  // known
  logic        out_tlast;  // last_of_frame
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  face_identity_label_stabilizer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tlast(in_tlast),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // predictor state: previous-frame and current-frame track tables
  track_t      prev_track[FACES];
  track_t      cur_track[FACES];
  bit [15:0]   claimed;
  int unsigned prev_cnt, cur_cnt;
  int unsigned min_hits_q, hold_frames_q;

  label_t      label_q[$];
  int          errors;
  int          tx_idle_pct, rx_idle_pct;
  int          cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // receiver: drop tready at random according to the current idle share
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic longint unsigned umax(longint unsigned a, longint unsigned b);
    return a > b ? a : b;
  endfunction

  function automatic longint unsigned umin(longint unsigned a, longint unsigned b);
    return a < b ? a : b;
  endfunction

  function automatic longint unsigned udist(longint unsigned a, longint unsigned b);
    return a > b ? a - b : b - a;
  endfunction

  // overlap score as a fraction; lifted to 1/4 when the centers sit close
  function automatic void overlap_score(track_t b, track_t s,
                                        output longint unsigned num,
                                        output longint unsigned den);
    longint unsigned x1, y1, x2, y2, iw, ih, inter, uni, dx, dy, mw, mh, lim;
    x1 = umax(b.x, s.x);
    y1 = umax(b.y, s.y);
    x2 = umin(b.x + b.w, s.x + s.w);
    y2 = umin(b.y + b.h, s.y + s.h);
    iw = x2 > x1 ? x2 - x1 : 0;
    ih = y2 > y1 ? y2 - y1 : 0;
    inter = iw * ih;
    uni = b.w * b.h + s.w * s.h - inter;
    dx = udist(b.x + b.w / 2, s.x + s.w / 2);
    dy = udist(b.y + b.h / 2, s.y + s.h / 2);
    mw = umax(b.w, s.w);
    mh = umax(b.h, s.h);
    lim = umax(NEAR_DIST_SQ, (mw * mw + mh * mh) / 4);
    num = inter;
    den = uni;
    if (dx * dx + dy * dy <= lim && uni > inter * 4) begin
      num = 1;
      den = 4;
    end
  endfunction

  function automatic void swap_tracks();
    prev_track = cur_track;
    prev_cnt = cur_cnt;
    cur_cnt = 0;
    claimed = '0;
  endfunction

  // advance the predictor by one word; return 1 when a label is due
  function automatic bit stabilize(face_t f, output label_t r);
    track_t          s, b;
    longint unsigned n, d, bn, bd;
    int              best;
    bit              room, known;
    bit [9:0]        id;
    logic signed [15:0] osc;
    r = '{default: 0};
    if (!f.valid) begin
      if (f.last) swap_tracks();
      return 0;
    end
    b = '{default: 0};
    b.x = umin(f.left, f.right);
    b.y = umin(f.top, f.bottom);
    b.w = umax(1, umax(f.left, f.right) - b.x);
    b.h = umax(1, umax(f.top, f.bottom) - b.y);
    s = '{default: 0};
    room = cur_cnt < FACES;
    if (room) begin
      best = -1;
      bn = 0;
      bd = 1;
      for (int i = 0; i < prev_cnt; i++) begin
        if (!claimed[i]) begin
          overlap_score(b, prev_track[i], n, d);
          if (n * bd > bn * d) begin
            bn = n;
            bd = d;
            best = i;
          end
        end
      end
      // accept when the best score reaches 3/20
      if (best >= 0 && !(3 * bd > bn * 20)) begin
        s = prev_track[best];
        claimed[best] = 1'b1;
      end
    end
    s.x = b.x; s.y = b.y; s.w = b.w; s.h = b.h;
    known = f.recognized;
    id = f.person;
    osc = f.score;
    if (!f.recognized) begin
      if (s.missed < COUNT_MAX) s.missed++;
      if (s.stab_v && s.missed <= hold_frames_q) begin
        known = 1'b1;
        id = s.stab_id;
        osc = f.score > s.stab_score ? f.score : s.stab_score;
      end else begin
        s.cand_v = 1'b0;
        s.cand_id = '0;
        s.hits = 0;
      end
    end else begin
      if (s.cand_v && s.cand_id == f.person) begin
        if (s.hits < COUNT_MAX) s.hits++;
      end else begin
        s.cand_v = 1'b1;
        s.cand_id = f.person;
        s.hits = 1;
      end
      s.missed = 0;
      if (s.hits >= min_hits_q) begin
        s.stab_v = 1'b1;
        s.stab_id = f.person;
        s.stab_score = f.score;
      end else if (s.stab_v && s.stab_id == f.person) begin
        osc = f.score > s.stab_score ? f.score : s.stab_score;
      end else begin
        known = 1'b0;
      end
    end
    if (room) begin
      cur_track[cur_cnt] = s;
      cur_cnt++;
    end
    r.known = known;
    r.id = known ? id : '0;
    r.score = osc;
    r.last = f.last;
    if (f.last) swap_tracks();
    return 1;
  endfunction

  // compare each accepted label word with the oldest prediction
  always @(posedge clk) begin : label_check
    label_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (label_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected label word, actual %h known %b last %b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        e = label_q.pop_front();
        if (out_tuser !== e.known) begin
          errors++;
          $display("%0t: known expected %b actual %b", $time, e.known, out_tuser);
        end
        if (out_tdata[9:0] !== e.id) begin
          errors++;
          $display("%0t: stable_id expected %0d actual %0d", $time, e.id, out_tdata[9:0]);
        end
        if (out_tdata[25:10] !== e.score) begin
          errors++;
          $display("%0t: reported score expected %h actual %h", $time, e.score,
                   out_tdata[25:10]);
        end
        if (out_tlast !== e.last) begin
          errors++;
          $display("%0t: last_of_frame expected %b actual %b", $time, e.last, out_tlast);
        end
      end
    end
  end

  // send one word; entered and left at a falling edge
  task automatic send_word(face_t f);
    label_t r;
    while ($urandom_range(99) < tx_idle_pct) @(negedge clk);
    in_tdata = {5'b0, f.score, f.person, f.recognized, f.bottom, f.right, f.top, f.left};
    in_tuser = f.valid;
    in_tlast = f.last;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    if (stabilize(f, r)) label_q = {label_q, r};
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_box(int l, int t, int rt, int b, bit rec, int pid, int sc, bit last);
    face_t f;
    f.valid = 1'b1;
    f.left = l; f.top = t; f.right = rt; f.bottom = b;
    f.recognized = rec;
    f.person = pid;
    f.score = sc;
    f.last = last;
    send_word(f);
  endtask

  task automatic send_empty(bit last, bit [79:0] junk);
    face_t f;
    f = '{default: 0};
    {f.score, f.person, f.recognized, f.bottom, f.right, f.top, f.left} = junk[74:0];
    f.last = last;
    send_word(f);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, int unsigned value);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = addr;
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_MIN_HITS) min_hits_q = value & 8'hff;
    else hold_frames_q = value & 8'hff;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  // hold until every label has arrived, then let a stray empty word finish
  task automatic drain();
    while (label_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_regs(int unsigned hits, int unsigned hold);
    drain();
    cfg_write(ADDR_MIN_HITS, hits);
    cfg_write(ADDR_HOLD_FRAMES, hold);
  endtask

  // corner words: extreme boxes, ids and scores, empty and ignored words,
  // near-center lift, hits up to stable, hold while unknown, id change
  task automatic test_corners();
    send_box(0, 0, 4095, 4095, 1, 1023, 32767, 0);
    send_box(4095, 4095, 0, 0, 1, 0, -32768, 0);
    send_box(100, 100, 100, 100, 0, 1023, 0, 0);
    send_box(100, 100, 140, 140, 1, 5, 1000, 1);
    send_empty(0, '1);
    send_empty(1, '0);
    send_box(100, 100, 140, 140, 1, 5, 2000, 1);
    send_box(101, 101, 141, 141, 1, 5, 3000, 1);
    send_box(102, 100, 142, 140, 1, 5, 1500, 1);
    // low overlap but close centers: still the same track
    send_box(130, 100, 170, 140, 0, 0, -5, 1);
    send_box(130, 100, 170, 140, 0, 7, 4000, 1);
    send_box(131, 100, 171, 140, 1, 9, 100, 1);
    send_box(131, 100, 171, 140, 1, 9, -100, 1);
    send_box(131, 100, 171, 140, 1, 5, 200, 1);
    send_box(3000, 3000, 3100, 3090, 1, 5, 200, 1);
    send_box(2000, 500, 2200, 700, 1, 12, -32768, 0);
    send_box(2010, 505, 2210, 705, 1, 12, 32767, 1);
    send_box(2010, 505, 2210, 705, 0, 12, 10, 1);
  endtask

  // more faces than slots: the extra ones start fresh and are not stored
  task automatic test_overflow();
    for (int fr = 0; fr < 2; fr++)
      for (int i = 0; i < 18; i++)
        send_box(i * 200, 50, i * 200 + 100, 150, 1, i, i * 100 - 900, i == 17);
  endtask

  // frames of moving tracked faces with noise, empty frames and ignored words
  task automatic test_tracks(int n_faces);
    int tx[6], ty[6], tw[6], th[6], tid[6];
    int n_tracks, sent, jl, jt, l, t, rt, b, tmp;
    bit rec;
    n_tracks = 0;
    sent = 0;
    while (sent < n_faces) begin
      if (n_tracks < 6 && $urandom_range(3) == 0) begin
        tx[n_tracks] = $urandom_range(3800);
        ty[n_tracks] = $urandom_range(3800);
        tw[n_tracks] = $urandom_range(200, 8);
        th[n_tracks] = $urandom_range(200, 8);
        tid[n_tracks] = $urandom_range(1023);
        n_tracks++;
      end
      if (n_tracks > 0 && $urandom_range(9) == 0) n_tracks--;
      case ($urandom_range(39))
        0: send_empty(1, {$urandom, $urandom, $urandom});
        1: begin
          test_overflow();
          sent += 36;
        end
        default: begin
          for (int i = 0; i < n_tracks; i++) begin
            jl = $urandom_range(6);
            jt = $urandom_range(6);
            tx[i] = tx[i] + jl - 3 < 0 ? 0 : tx[i] + jl - 3;
            ty[i] = ty[i] + jt - 3 < 0 ? 0 : ty[i] + jt - 3;
            l = tx[i]; t = ty[i];
            rt = tx[i] + tw[i]; b = ty[i] + th[i];
            if ($urandom_range(7) == 0) begin
              tmp = l; l = rt; rt = tmp;
            end
            rec = $urandom_range(9) < 7;
            if ($urandom_range(15) == 0) tid[i] = $urandom_range(1023);
            send_box(l, t, rt, b, rec, rec ? tid[i] : $urandom_range(1023),
                     $signed(16'($urandom)), 0);
            sent++;
          end
          if ($urandom_range(4) == 0) begin
            send_box($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                     $urandom_range(4095), $urandom_range(1), $urandom_range(1023),
                     $signed(16'($urandom)), 0);
            sent++;
          end
          if ($urandom_range(7) == 0) send_empty(0, {$urandom, $urandom, $urandom});
          // close the frame with a face or with an empty word
          if ($urandom_range(1)) begin
            send_box($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                     $urandom_range(4095), $urandom_range(1), $urandom_range(1023),
                     $signed(16'($urandom)), 1);
            sent++;
          end else begin
            send_empty(1, {$urandom, $urandom, $urandom});
          end
        end
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    in_tvalid = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    errors = 0;
    cycles = 0;
    claimed = '0;
    prev_cnt = 0;
    cur_cnt = 0;
    min_hits_q = MIN_HITS_RST;
    hold_frames_q = HOLD_FRAMES_RST;
    tx_idle_pct = 19;
    rx_idle_pct = 71;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_corners();
    set_regs(0, 255);
    test_overflow();

    set_regs(1, 0);
    test_tracks(650);

    tx_idle_pct = 71;
    rx_idle_pct = 19;
    set_regs(255, 255);
    test_tracks(650);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_regs(3, 5);
    test_tracks(650);

    drain();
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
